[src/ntt_pkg.sv]
// Package for the mod-3329 NTT engine: constants, state and control types,
// twiddle table. No dependencies.
package ntt_pkg;
  localparam int unsigned Q = 3329;
  localparam int unsigned LANES = 4;
  localparam int unsigned POLY_LEN = 256;
  localparam int unsigned ITEMS = POLY_LEN / LANES;
  localparam int unsigned ZETA_COUNT = 128;
  localparam int unsigned BARRETT_M = 5039;  // floor(2^24 / Q)
  localparam logic [11:0] INV_SCALE = 12'd3303;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD, ST_WAIT, ST_MUL, ST_WB, ST_OUT_RD, ST_OUT_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic        inv;
    logic        scale;
    logic [11:0] zeta;
  } bfly_ctl_t;

  // 17 to the bit-reversed 7-bit exponent of k, packed 12 bits per entry
  function automatic logic [12*ZETA_COUNT-1:0] zeta_table();
    logic [12*ZETA_COUNT-1:0] tab;
    int unsigned e;
    int unsigned acc;
    int unsigned b;
    tab = '0;
    for (int k = 0; k < ZETA_COUNT; k++) begin
      e = 0;
      for (int i = 0; i < 7; i++) e = (e << 1) | ((k >> i) & 1);
      acc = 1;
      b = 17;
      for (int i = 0; i < 7; i++) begin
        if (((e >> i) & 1) != 0) acc = (acc * b) % Q;
        b = (b * b) % Q;
      end
      tab[12*k +: 12] = acc[11:0];
    end
    return tab;
  endfunction

  localparam logic [12*ZETA_COUNT-1:0] ZETAS = zeta_table();
endpackage

[src/ntt_bfly.sv]
// Shared butterfly unit: pipelined mod-q multiply with Barrett reduction; add/sub
// after it (forward) or before it (inverse), none in scale mode. Depends on ntt_pkg.
module ntt_bfly import ntt_pkg::*; (
  input  logic        clk,
  input  bfly_ctl_t   ctl,
  input  logic [11:0] a,
  input  logic [11:0] b,
  output logic [11:0] ya,
  output logic [11:0] yb
);
  logic [12:0] sum, dif;
  logic [11:0] sum_m, dif_m, mop;
  logic [23:0] prod_r, prod_nxt;
  logic [11:0] a_r, b_r;
  logic [36:0] est;
  logic [11:0] quot_r, quot_nxt;
  logic [23:0] prod2_r;
  logic [11:0] a2_r, b2_r;
  logic [12:0] rem;
  logic [11:0] red;
  logic [12:0] ta, tb;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    sum_m = (sum >= 13'(Q)) ? 12'(sum - 13'(Q)) : sum[11:0];
    dif = {1'b0, b} + 13'(Q) - {1'b0, a};
    dif_m = (dif >= 13'(Q)) ? 12'(dif - 13'(Q)) : dif[11:0];
    mop = ctl.scale ? a : (ctl.inv ? dif_m : b);
    prod_nxt = {12'd0, mop} * {12'd0, ctl.zeta};
    est = {13'd0, prod_r} * 37'(BARRETT_M);
    quot_nxt = est[35:24];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    a_r <= ctl.inv ? sum_m : a;
    b_r <= b;
    quot_r <= quot_nxt;
    prod2_r <= prod_r;
    a2_r <= a_r;
    b2_r <= b_r;
  end

  always_comb begin
    rem = 13'(prod2_r - {12'd0, quot_r} * 24'(Q));
    red = (rem >= 13'(Q)) ? 12'(rem - 13'(Q)) : rem[11:0];
    ta = {1'b0, a2_r} + {1'b0, red};
    tb = {1'b0, a2_r} + 13'(Q) - {1'b0, red};
    if (ctl.scale) begin
      ya = red;
      yb = b2_r;
    end else if (ctl.inv) begin
      ya = a2_r;
      yb = red;
    end else begin
      ya = (ta >= 13'(Q)) ? 12'(ta - 13'(Q)) : ta[11:0];
      yb = (tb >= 13'(Q)) ? 12'(tb - 13'(Q)) : tb[11:0];
    end
  end
endmodule

[src/ntt_mod3329_engine.sv]
// NTT engine top: sequencer, coefficient RAM, stream ports.
// Load 64 words (one/cycle while in_tvalid); transform 896 butterflies, each through
// ST_RD, ST_WAIT, ST_MUL, ST_WB (inverse adds 256 scale passes through the same states);
// then 64 output words, each read from RAM one lane at a time before ST_OUT.
// A new polynomial is accepted only after the last output word of the previous one.
// Reset: synchronous active-low rst_n clears control; RAM is not cleared.
module ntt_mod3329_engine import ntt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coeff_in_0..coeff_in_3, 12 bits each
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // coeff_out_0..coeff_out_3, 12 bits each
  output logic        out_tlast   // final_group
);
  logic [11:0] mem [POLY_LEN];
  state_t      state_r, state_nxt;
  logic        dir_r, inv_r;
  logic [5:0]  cnt_r;
  logic [2:0]  layer_r;
  logic [6:0]  bf_r;
  logic        scale_r;
  logic [7:0]  scl_r;
  logic [7:0]  ia, ib;
  logic [11:0] ra_r, rb_r, ya, yb;
  logic [11:0] o_r [LANES];
  logic [1:0]  oc_r;
  logic        olast_r;
  logic [6:0]  k_idx;
  logic [2:0]  lg;
  logic [7:0]  len, grp;
  bfly_ctl_t   ctl;

  always_comb begin
    lg = inv_r ? 3'(layer_r + 3'd1) : 3'(3'd7 - layer_r);
    len = 8'd1 << lg;
    grp = 8'(bf_r) >> lg;
    ia = 8'((grp << (lg + 3'd1)) | (8'(bf_r) & (len - 8'd1)));
    ib = ia + len;
    k_idx = inv_r ? 7'((8'd128 >> layer_r) - 8'd1 - grp)
                  : 7'((8'd1 << layer_r) + grp);
    ctl.inv = inv_r;
    ctl.scale = scale_r;
    ctl.zeta = scale_r ? INV_SCALE : ZETAS[12*k_idx +: 12];
  end

  ntt_bfly u_bfly (.clk(clk), .ctl(ctl), .a(ra_r), .b(rb_r), .ya(ya), .yb(yb));

  logic [11:0] lin [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lin[l] = in_tdata[12*l +: 12];
      if (lin[l] >= 12'(Q)) lin[l] = 12'(lin[l] - 12'(Q));
    end
  end

  logic [7:0] rda, rdb;
  always_comb begin
    rda = scale_r ? scl_r : ia;
    rdb = ib;
    if (state_r == ST_OUT_RD || state_r == ST_OUT_WAIT) rda = {cnt_r, oc_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && in_tvalid) begin
      for (int l = 0; l < LANES; l++) mem[{cnt_r, 2'(l)}] <= lin[l];
    end else if (state_r == ST_WB) begin
      mem[rda] <= ya;
      if (!scale_r) mem[rdb] <= yb;
    end
    ra_r <= mem[rda];
    rb_r <= mem[rdb];
    if (state_r == ST_OUT_WAIT) o_r[oc_r] <= mem[rda];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      dir_r <= 1'b0;
      inv_r <= 1'b0;
      cnt_r <= '0;
      layer_r <= '0;
      bf_r <= '0;
      scale_r <= 1'b0;
      scl_r <= '0;
      oc_r <= '0;
      olast_r <= 1'b0;
    end else begin
      if (cfg_we) dir_r <= cfg_wdata;
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: if (in_tvalid) begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(ITEMS - 1)) begin
            inv_r <= dir_r;
            layer_r <= '0;
            bf_r <= '0;
            scale_r <= 1'b0;
            scl_r <= '0;
          end
        end
        ST_WB: begin
          if (scale_r) begin
            scl_r <= scl_r + 8'd1;
          end else begin
            bf_r <= bf_r + 7'd1;
            if (bf_r == 7'd127) begin
              layer_r <= layer_r + 3'd1;
              if (layer_r == 3'd6 && inv_r) scale_r <= 1'b1;
            end
          end
          if (state_nxt == ST_OUT_RD) begin
            cnt_r <= '0;
            oc_r <= '0;
          end
        end
        ST_OUT_WAIT: oc_r <= oc_r + 2'd1;
        ST_OUT: if (out_tready) begin
          cnt_r <= cnt_r + 6'd1;
        end
        default: ;
      endcase
      olast_r <= (cnt_r == 6'(ITEMS - 1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_tvalid && cnt_r == 6'(ITEMS - 1)) state_nxt = ST_RD;
      ST_RD:       state_nxt = ST_WAIT;
      ST_WAIT:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_WB;
      ST_WB: begin
        if (scale_r ? (scl_r == 8'd255)
                    : (bf_r == 7'd127 && layer_r == 3'd6 && !inv_r))
          state_nxt = ST_OUT_RD;
        else
          state_nxt = ST_RD;
      end
      ST_OUT_RD:   state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: state_nxt = (oc_r == 2'd3) ? ST_OUT : ST_OUT_RD;
      ST_OUT: if (out_tready) state_nxt = (cnt_r == 6'(ITEMS - 1)) ? ST_LOAD : ST_OUT_RD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  assign in_tready = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {o_r[3], o_r[2], o_r[1], o_r[0]};
  assign out_tlast = olast_r;

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready and valid together");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("no return to load after last");
  a_scl: assert property (@(posedge clk) disable iff (!rst_n) !scale_r || inv_r)
    else $error("scale pass outside inverse");
`endif
endmodule
